// ===== sv/rotary_encoder_edge_decoder_unit_assert.svh =====
`ifndef ROTARY_ENCODER_EDGE_DECODER_UNIT_ASSERT_SVH
`define ROTARY_ENCODER_EDGE_DECODER_UNIT_ASSERT_SVH

// same-cycle check
`define REDEC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle check
`define REDEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/redec_pkg.sv =====
package redec_pkg;

   localparam int unsigned LOCKOUT_W = 8;
   localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 8'd5;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_RIGHT  = 2'd1,
      KIND_LEFT   = 2'd2,
      KIND_BUTTON = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      EV_ROT_LEFT  = 2'd0,
      EV_ROT_RIGHT = 2'd1,
      EV_BUTTON    = 2'd2
   } event_type;

   typedef struct packed {
      kind_type kind;
      logic     right_level;
      logic     left_level;
   } item_type;

   typedef struct packed {
      logic      valid;
      event_type ev;
   } result_type;

   typedef struct packed {
      logic                 right_armed;
      logic                 left_armed;
      logic [LOCKOUT_W-1:0] lockout_count;
   } state_type;

endpackage

// ===== sv/redec_in_stage.sv =====
module redec_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic               req_right_level,
   input  logic               req_left_level,
   input  logic               advance,
   output logic               in_valid,
   output redec_pkg::item_type item
);
   import redec_pkg::*;

   logic     in_valid_ff;
   logic     in_valid_in;
   item_type item_ff;
   logic     accept;

   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind        <= kind_type'(req_kind);
         item_ff.right_level <= req_right_level;
         item_ff.left_level  <= req_left_level;
      end
   end

   assign in_valid = in_valid_ff;
   assign item     = item_ff;

endmodule

// ===== sv/redec_core.sv =====
module redec_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [redec_pkg::LOCKOUT_W-1:0] csr_data,
   input  logic                      in_valid,
   input  redec_pkg::item_type       item,
   input  logic                      advance,
   output redec_pkg::result_type     res,
   output redec_pkg::state_type      state
);
   import redec_pkg::*;

   state_type            state_ff;
   state_type            state_in;
   logic [LOCKOUT_W-1:0] lockout_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ticks_ff <= LOCKOUT_RESET;
      end else if (csr_write) begin
         lockout_ticks_ff <= csr_data;
      end
   end

   always_comb begin
      state_in  = state_ff;
      res.valid = 1'b0;
      res.ev    = EV_BUTTON;
      case (item.kind)
         KIND_TICK: begin
            if (item.right_level && item.left_level) begin
               state_in.right_armed = 1'b0;
               state_in.left_armed  = 1'b0;
            end
            if (state_ff.lockout_count != '0) begin
               state_in.lockout_count = state_ff.lockout_count - 1'b1;
            end
         end
         KIND_RIGHT: begin
            if (state_ff.lockout_count == '0) begin
               if (state_ff.left_armed && !item.left_level) begin
                  state_in.lockout_count = lockout_ticks_ff;
                  state_in.right_armed   = 1'b0;
                  state_in.left_armed    = 1'b0;
                  res.valid              = in_valid;
                  res.ev                 = EV_ROT_LEFT;
               end else begin
                  state_in.right_armed = 1'b1;
               end
            end
         end
         KIND_LEFT: begin
            if (state_ff.lockout_count == '0) begin
               if (state_ff.right_armed && !item.right_level) begin
                  state_in.lockout_count = lockout_ticks_ff;
                  state_in.right_armed   = 1'b0;
                  state_in.left_armed    = 1'b0;
                  res.valid              = in_valid;
                  res.ev                 = EV_ROT_RIGHT;
               end else begin
                  state_in.left_armed = 1'b1;
               end
            end
         end
         default: begin
            state_in.right_armed = 1'b0;
            state_in.left_armed  = 1'b0;
            res.valid            = in_valid;
            res.ev               = EV_BUTTON;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ===== sv/redec_out_stage.sv =====
module redec_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  redec_pkg::result_type res,
   output logic                  out_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_event_res
);
   import redec_pkg::*;

   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   event_type ev_ff;
   logic      load;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign load      = advance && res.valid;

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ev_ff <= res.ev;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = 2'(ev_ff);

endmodule

// ===== sv/rotary_encoder_edge_decoder_unit.sv =====
// Rotary encoder edge decoder: turns encoder line edges, button edges and
// timer ticks into rotate-left, rotate-right and button-press events.
// req channel: one event beat (kind, right_level, left_level) per cycle,
// accepted when req_valid is high and req_stall is low.
// rsp channel: one event_res beat (0 left, 1 right, 2 button) for items that
// produce a result; ticks, armed-only edges and locked-out edges give none.
// csr channel: write of lockout_ticks, taken whenever csr_valid is high,
// csr_ready is always high; write only while the block is idle.
// Throughput: one item per cycle unless a result waits on rsp_stall, limited
// by the input register feeding the decode logic and the result register.
// Path: an accepted item sits in the input register, is decoded from it, and
// its result is loaded into the result register, which drives rsp_valid.
// Reset (synchronous): flags and lockout counter clear, lockout_ticks = 5,
// both valid registers clear.
// A stalled rsp beat holds; items without a result keep flowing, an item
// with a result waits in the input register, which raises req_stall.
`include "rotary_encoder_edge_decoder_unit_assert.svh"

module rotary_encoder_edge_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic       req_right_level,
   input  logic       req_left_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_res,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);
   import redec_pkg::*;

   logic       in_valid;
   item_type   item;
   result_type res;
   state_type  state;
   logic       out_ready;
   logic       advance;

   assign csr_ready = 1'b1;
   assign advance   = in_valid && (!res.valid || out_ready);

   redec_in_stage u_in (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_right_level (req_right_level),
      .req_left_level  (req_left_level),
      .advance         (advance),
      .in_valid        (in_valid),
      .item            (item)
   );

   redec_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .in_valid  (in_valid),
      .item      (item),
      .advance   (advance),
      .res       (res),
      .state     (state)
   );

   redec_out_stage u_out (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .res           (res),
      .out_ready     (out_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_event_res (rsp_event_res)
   );

   `REDEC_ASSERT_NEXT(a_result_clears_flags, advance && res.valid,
      !state.right_armed && !state.left_armed, "flags not cleared after result")
   `REDEC_ASSERT_NOW(a_rotation_not_locked, res.valid && res.ev != EV_BUTTON,
      state.lockout_count == '0, "rotation reported during lockout")
   `REDEC_ASSERT_NOW(a_stall_from_output, req_stall,
      rsp_valid && rsp_stall, "req_stall without output backpressure")

endmodule
